>>> rtl/bda_pkg.sv
// Shared types, constants and helpers for the binary to decimal ASCII unit.
`timescale 1ns / 1ps
package bda_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int IN_DATA_W      = 64;
  localparam int OUT_DATA_W     = 8;
  localparam int DIGIT_CHAR_W   = 6;
  localparam int NIBBLE_W       = 4;

  localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [NIBBLE_W-1:0]     DABBLE_MIN = 4'd5;
  localparam logic [NIBBLE_W-1:0]     DABBLE_ADD = 4'd3;

  // Decimal digits of the largest VALUE_BITS number: floor(bits * log10(2)) + 1.
  // 1233 / 4096 approximates log10(2) closely enough for up to 64 bits.
  function automatic int bda_digits(input int bits);
    int prod;
    prod = bits * 1233;
    return (prod >> 12) + 1;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } bda_state_t;

  typedef struct packed {
    logic load;        // capture a new value, clear the BCD register
    logic dabble;      // one add-3 and shift step
    logic shift_digit; // drop the top digit
    logic load_out;    // copy the top digit into the output register
    logic out_last;    // flag that goes with load_out
  } bda_cmd_t;

  typedef struct packed {
    logic top_zero;    // top BCD digit is zero
  } bda_stat_t;

endpackage

>>> rtl/bda_dp.sv
// Datapath: value shift register, BCD register with double dabble, output register.
`timescale 1ns / 1ps
module bda_dp #(
  parameter int VALUE_BITS = bda_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic [VALUE_BITS-1:0]               in_value,
  input  bda_pkg::bda_cmd_t                   cmd,
  output bda_pkg::bda_stat_t                  stat,
  output logic [bda_pkg::DIGIT_CHAR_W-1:0]    digit_char,
  output logic                                last_digit
);
  import bda_pkg::*;

  localparam int DIGITS = bda_digits(VALUE_BITS);
  localparam int BCD_W  = DIGITS * NIBBLE_W;

  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [BCD_W-1:0]        bcd_adj;
  logic [NIBBLE_W-1:0]     top_digit;
  logic [DIGIT_CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  // Add 3 to every digit of 5 or more; the digits are independent.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*NIBBLE_W +: NIBBLE_W] >= DABBLE_MIN) begin
        bcd_adj[i*NIBBLE_W +: NIBBLE_W] = bcd_r[i*NIBBLE_W +: NIBBLE_W] + DABBLE_ADD;
      end else begin
        bcd_adj[i*NIBBLE_W +: NIBBLE_W] = bcd_r[i*NIBBLE_W +: NIBBLE_W];
      end
    end
  end

  assign top_digit     = bcd_r[BCD_W-1 -: NIBBLE_W];
  assign stat.top_zero = (top_digit == '0);

  always_comb begin
    val_nxt      = val_r;
    bcd_nxt      = bcd_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    if (cmd.load) begin
      val_nxt = in_value;
      bcd_nxt = '0;
    end else if (cmd.dabble) begin
      val_nxt = {val_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], val_r[VALUE_BITS-1]};
    end else if (cmd.shift_digit) begin
      bcd_nxt = {bcd_r[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
    end
    if (cmd.load_out) begin
      out_char_nxt = ASCII_ZERO + {{(DIGIT_CHAR_W-NIBBLE_W){1'b0}}, top_digit};
      out_last_nxt = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign digit_char = out_char_r;
  assign last_digit = out_last_r;

endmodule

>>> rtl/bda_ctrl.sv
// Controller: sequences conversion and digit emission, owns the handshakes.
`timescale 1ns / 1ps
module bda_ctrl #(
  parameter int VALUE_BITS = bda_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  bda_pkg::bda_stat_t stat,
  output bda_pkg::bda_cmd_t  cmd
);
  import bda_pkg::*;

  localparam int DIGITS = bda_digits(VALUE_BITS);
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_CONV = CNT_W'(VALUE_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_EMIT = CNT_W'(DIGITS - 1);

  bda_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             started_r, started_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;
  logic             cnt_zero;
  logic             skip;

  assign slot_free = !out_valid_r || out_tready;
  assign cnt_zero  = (cnt_r == '0);
  // Leading zeros are dropped, but the units digit always goes out.
  assign skip      = !started_r && stat.top_zero && !cnt_zero;

  // Next state, counter and started flag.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt   = ST_CONV;
          cnt_nxt     = CNT_CONV;
          started_nxt = 1'b0;
        end
      end
      ST_CONV: begin
        if (cnt_zero) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = CNT_EMIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (!skip) begin
            started_nxt = 1'b1;
          end
          if (cnt_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
      end
      ST_EMIT: begin
        cmd.shift_digit = slot_free;
        cmd.load_out    = slot_free && !skip;
        cmd.out_last    = cnt_zero;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/binary_to_decimal_ascii_unit.sv
// Top level of the binary to decimal ASCII converter.
//
// Usage: each input word on the in_ stream is one unsigned number; its low
// VALUE_BITS bits are converted and the decimal digits leave on the out_
// stream as ASCII characters, most significant digit first, one per word.
// Leading zeros are suppressed; zero prints as a single '0'. out_tlast is
// high on the final digit of each number.
// Operation: after acceptance a bit-serial double dabble runs, one step per
// input bit. The emit phase then walks the BCD register one digit per cycle
// while the receiver does not stall, dropping leading zeros, over all
// bda_digits(VALUE_BITS) digits (20 by default). The serial dabble loop and
// the digit walk share one register set, so a new number is taken only once
// the digit walk of the last one is through.
// A single output register holds the current character; while the receiver
// stalls, the emit phase waits. in_tready rises again as soon as the final
// digit sits in the output register, so the next number can be taken while
// that digit still waits to be read.
// Reset (rst_n low, synchronous) returns the block to idle and drops any
// pending character.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = bda_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bda_pkg::IN_DATA_W-1:0]  in_tdata,   // [63:0] value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bda_pkg::OUT_DATA_W-1:0] out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic                           out_tlast   // last_digit
);
  import bda_pkg::*;

  bda_cmd_t                cmd;
  bda_stat_t               stat;
  logic [DIGIT_CHAR_W-1:0] digit_char;
  logic                    last_digit;

  // The controller decides what happens each cycle; the datapath only acts
  // on its commands and reports whether the top BCD digit is zero.
  bda_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Bits of the input word above VALUE_BITS are ignored here.
  bda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .in_value   (in_tdata[VALUE_BITS-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  assign out_tdata = {{(OUT_DATA_W-DIGIT_CHAR_W){1'b0}}, digit_char};
  assign out_tlast = last_digit;

  // One number at a time: right after an accept the input side is closed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a conversion was starting");

  // Every character shown is an ASCII decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] >= 6'd48 && out_tdata[5:0] <= 6'd57))
    else $error("output character is not a decimal digit");

  // Once idle, only the final digit of the previous number may still wait.
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && out_tvalid) |-> out_tlast)
    else $error("idle while a non-final digit is pending");

  // A character that is not taken stays on the bus unchanged.
  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output word changed while the receiver stalled");

endmodule
